/* rtl/dsi_pkg.sv */
package dsi_pkg;

  localparam int unsigned CpWidth  = 32;
  localparam int unsigned AccWidth = 64;

  localparam logic [CpWidth-1:0] CP_MINUS = 32'd45;
  localparam logic [CpWidth-1:0] CP_ZERO  = 32'd48;
  localparam logic [CpWidth-1:0] CP_NINE  = 32'd57;
  localparam logic [CpWidth-1:0] CP_TAB   = 32'd9;
  localparam logic [CpWidth-1:0] CP_CR    = 32'd13;
  localparam logic [CpWidth-1:0] CP_SPACE = 32'd32;

  // floor((2^63-1)/10) and the last digit that still fits
  localparam logic [AccWidth-1:0] ACC_LIMIT_DIV10 = 64'd922337203685477580;
  localparam logic [3:0]          ACC_LIMIT_LAST  = 4'd7;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_BLANK,
    CLS_DIGIT,
    CLS_MINUS,
    CLS_OTHER
  } char_class_e;

  // One classified character as it leaves the input register
  typedef struct packed {
    char_class_e cls;
    logic [3:0]  digit;
    logic        last;
  } item_t;

  function automatic char_class_e classify(input logic [CpWidth-1:0] cp,
                                           input logic               cv);
    char_class_e cls;
    cls = CLS_OTHER;
    if (!cv) begin
      cls = CLS_NONE;
    end else if ((cp >= CP_TAB && cp <= CP_CR) || cp == CP_SPACE) begin
      cls = CLS_BLANK;
    end else if (cp >= CP_ZERO && cp <= CP_NINE) begin
      cls = CLS_DIGIT;
    end else if (cp == CP_MINUS) begin
      cls = CLS_MINUS;
    end
    return cls;
  endfunction

endpackage

/* rtl/dsi_in_if.sv */
interface dsi_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_point;
  logic        char_valid;
  logic        last_char;

  modport source (output valid, output code_point, output char_valid,
                  output last_char, input ready);
  modport sink   (input valid, input code_point, input char_valid,
                  input last_char, output ready);
endinterface

/* rtl/dsi_out_if.sv */
interface dsi_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic               parse_error;
  logic               overflowed;

  modport source (output valid, output value, output parse_error,
                  output overflowed, input ready);
  modport sink   (input valid, input value, input parse_error,
                  input overflowed, output ready);
endinterface

/* rtl/dsi_in_reg.sv */
module dsi_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  dsi_in_if.sink        in_i,
  input  logic          adv_i,
  output dsi_pkg::item_t item_o,
  output logic          item_valid_o
);
  import dsi_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  // take a new request whenever the register is empty or drains this cycle
  assign in_i.ready = !valid_q || adv_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (adv_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d      = 1'b1;
      item_d.cls   = classify(in_i.code_point, in_i.char_valid);
      item_d.digit = in_i.code_point[3:0];
      item_d.last  = in_i.last_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule

/* rtl/dsi_parse.sv */
module dsi_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dsi_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           adv_o,
  dsi_out_if.source      out_o
);
  import dsi_pkg::*;

  logic [AccWidth-1:0] acc_q, acc_d;
  logic                past_q, past_d;
  logic                neg_q, neg_d;
  logic                err_q, err_d;
  logic                ovf_q, ovf_d;

  logic                out_valid_q, out_valid_d;
  logic [AccWidth-1:0] value_q, value_d;
  logic                perr_q, perr_d;
  logic                povf_q, povf_d;

  logic                out_free;
  logic [AccWidth-1:0] acc_x10;
  logic                digit_ovf;

  // a last item needs the result register; any other item drains at once
  assign out_free = !out_valid_q || out_o.ready;
  assign adv_o    = item_valid_i && (!item_i.last || out_free);

  assign acc_x10   = {acc_q[AccWidth-4:0], 3'b000} + {acc_q[AccWidth-2:0], 1'b0};
  assign digit_ovf = (acc_q > ACC_LIMIT_DIV10) ||
                     (acc_q == ACC_LIMIT_DIV10 && item_i.digit > ACC_LIMIT_LAST);

  always_comb begin
    logic fall;
    acc_d       = acc_q;
    past_d      = past_q;
    neg_d       = neg_q;
    err_d       = err_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;
    perr_d      = perr_q;
    povf_d      = povf_q;
    fall        = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (adv_o) begin
      if (item_i.cls != CLS_NONE && !err_q) begin
        if (!past_q) begin
          if (item_i.cls != CLS_BLANK) begin
            past_d = 1'b1;
            if (item_i.cls == CLS_MINUS) begin
              neg_d = 1'b1;
            end else begin
              fall = 1'b1;
            end
          end
        end else begin
          fall = 1'b1;
        end
        if (fall) begin
          case (item_i.cls)
            CLS_DIGIT: begin
              ovf_d = ovf_q || digit_ovf;
              acc_d = acc_x10 + {{(AccWidth-4){1'b0}}, item_i.digit};
            end
            CLS_BLANK: ;
            default:   err_d = 1'b1;
          endcase
        end
      end

      if (item_i.last) begin
        out_valid_d = 1'b1;
        value_d     = err_d ? '0 : (neg_d ? ('0 - acc_d) : acc_d);
        perr_d      = err_d;
        povf_d      = ovf_d;
        // drop the string state for the next request
        acc_d       = '0;
        past_d      = 1'b0;
        neg_d       = 1'b0;
        err_d       = 1'b0;
        ovf_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      past_q      <= 1'b0;
      neg_q       <= 1'b0;
      err_q       <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      past_q      <= past_d;
      neg_q       <= neg_d;
      err_q       <= err_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    perr_q  <= perr_d;
    povf_q  <= povf_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.value       = value_q;
  assign out_o.parse_error = perr_q;
  assign out_o.overflowed  = povf_q;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_o && item_i.last) |=> (acc_q == '0 && !past_q && !neg_q && !err_q && !ovf_q))
    else $error("string state not cleared after last item");

  a_error_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && perr_q) |-> (value_q == '0))
    else $error("result with parse error carries a nonzero value");

  a_error_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && !(adv_o && item_i.last)) |=> ($stable(acc_q) && err_q))
    else $error("accumulator moved after an error");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && !(adv_o && item_i.last)) |=> ovf_q)
    else $error("overflow flag dropped within a string");

  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_o && item_i.last) |-> out_free)
    else $error("result register overwritten while still held");

endmodule

/* rtl/decimal_string_to_integer_core.sv */
// Signed decimal string parser. Characters arrive one 32-bit code point per
// request on in_i, the final request of a string flagged by last_char; a
// request with char_valid low carries no character (use it to end an empty
// string). Leading blanks (code points 9..13 and 32) are skipped, one minus
// sign may precede the first digit, later blanks are ignored, and any other
// character sets parse_error and forces value to zero. The last request of a
// string produces exactly one result on out_o: the two's complement value
// (wrapping modulo 2^64), parse_error, and overflowed, which is set once the
// magnitude has passed 2^63-1. Throughput is one request per clock while no
// last request is held waiting for the result register; a result passes
// through the input register and then the result register, which loads when
// the last request drains from the input register. The accumulator loop,
// acc*10 + digit done as a combinational shift-add, sets the clock rate. The
// block keeps accepting requests while a result waits on out_o; only a
// further last request waits for that result to be taken.
module decimal_string_to_integer_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsi_in_if.sink    in_i,
  dsi_out_if.source out_o
);
  import dsi_pkg::*;

  item_t item;
  logic  item_valid;
  logic  adv;

  // Register and classify each incoming character.
  dsi_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .adv_i        (adv),
    .item_o       (item),
    .item_valid_o (item_valid)
  );

  // Advance the parse state and load the result on the last character.
  dsi_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .adv_o        (adv),
    .out_o        (out_o)
  );

endmodule
